// ===== sv/cdqs_pkg.sv =====
`timescale 1ns / 1ps
// cdqs_pkg: shared types and codes for the circular deque with search.
// Used by the controller, the datapath and the checker; no dependencies.

package cdqs_pkg;

	localparam int CMD_W   = 3;
	localparam int VALUE_W = 32;
	localparam int STAT_W  = 2;
	localparam int SLOT_W  = 6;
	localparam int OCC_W   = 7;
	localparam int CAP_W   = 7;

	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd2;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP,
		S_SCAN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic load_in;
		logic exec;
		logic pop_capture;
		logic scan_step;
		logic finish_load;
	} ctl_t;

	typedef struct packed {
		logic pop_ok;
		logic search_go;
		logic scan_hit;
		logic scan_miss;
		logic out_free;
	} sts_t;

endpackage

// ===== sv/cdqs_ctrl.sv =====
`timescale 1ns / 1ps
// cdqs_ctrl: sequencing state machine for the deque.
// Depends on cdqs_pkg for the state, status and control types.

module cdqs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           cfg_ready,
	input  cdqs_pkg::sts_t sts,
	output cdqs_pkg::ctl_t ctl
);

	cdqs_pkg::state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cdqs_pkg::S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n   = state_q;
		ctl       = '0;
		in_stall  = 1'b1;
		cfg_ready = 1'b0;
		unique case (state_q)
			cdqs_pkg::S_IDLE: begin
				in_stall  = 1'b0;
				cfg_ready = 1'b1;
				if (in_valid) begin
					ctl.load_in = 1'b1;
					state_n     = cdqs_pkg::S_EXEC;
				end
			end
			cdqs_pkg::S_EXEC: begin
				ctl.exec = 1'b1;
				if (sts.pop_ok) begin
					state_n = cdqs_pkg::S_POP;
				end else if (sts.search_go) begin
					state_n = cdqs_pkg::S_SCAN;
				end else begin
					state_n = cdqs_pkg::S_FINISH;
				end
			end
			cdqs_pkg::S_POP: begin
				ctl.pop_capture = 1'b1;
				state_n         = cdqs_pkg::S_FINISH;
			end
			cdqs_pkg::S_SCAN: begin
				ctl.scan_step = 1'b1;
				if (sts.scan_hit || sts.scan_miss) begin
					state_n = cdqs_pkg::S_FINISH;
				end
			end
			cdqs_pkg::S_FINISH: begin
				if (sts.out_free) begin
					ctl.finish_load = 1'b1;
					state_n         = cdqs_pkg::S_IDLE;
				end
			end
			default: begin
				state_n = cdqs_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/cdqs_dp.sv =====
`timescale 1ns / 1ps
// cdqs_dp: slot memory, pointers, occupancy, scan pipeline and output register.
// Depends on cdqs_pkg; driven by cdqs_ctrl through ctl_t, reports via sts_t.

module cdqs_dp #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [cdqs_pkg::CMD_W-1:0]          command,
	input  logic signed [cdqs_pkg::VALUE_W-1:0] value,
	input  logic                                cfg_we,
	input  logic [cdqs_pkg::CAP_W-1:0]          capacity,
	input  logic                                out_stall,
	output logic                                out_valid,
	output logic [cdqs_pkg::STAT_W-1:0]         status,
	output logic signed [cdqs_pkg::VALUE_W-1:0] popped_value,
	output logic [cdqs_pkg::SLOT_W-1:0]         found_slot,
	output logic [cdqs_pkg::OCC_W-1:0]          occupancy,
	input  cdqs_pkg::ctl_t                      ctl,
	output cdqs_pkg::sts_t                      sts
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int W  = (DATA_WIDTH > cdqs_pkg::VALUE_W) ? DATA_WIDTH : cdqs_pkg::VALUE_W;
	localparam int SW = (CW > cdqs_pkg::OCC_W) ? CW : cdqs_pkg::OCC_W;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p, input logic [CW-1:0] cap);
		logic [CW-1:0] n;
		n = CW'(p) + CW'(1);
		return (n >= cap) ? '0 : n[PW-1:0];
	endfunction

	function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p, input logic [CW-1:0] cap);
		logic [CW-1:0] m;
		m = cap - CW'(1);
		return (p == '0) ? m[PW-1:0] : p - PW'(1);
	endfunction

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	logic [PW-1:0]                head_q, tail_q, scan_ptr_q, rd_slot_q;
	logic [CW-1:0]                count_q, cap_q, issue_left_q;
	logic                         rd_vld_q, out_valid_q;
	logic [cdqs_pkg::CMD_W-1:0]   cmd_q;
	logic [DATA_WIDTH-1:0]        val_q, rd_data_q;

	logic [cdqs_pkg::STAT_W-1:0]  res_status_q;
	logic [cdqs_pkg::VALUE_W-1:0] res_popped_q;
	logic [cdqs_pkg::SLOT_W-1:0]  res_slot_q;

	logic [cdqs_pkg::STAT_W-1:0]  out_status_q;
	logic [cdqs_pkg::VALUE_W-1:0] out_popped_q;
	logic [cdqs_pkg::SLOT_W-1:0]  out_slot_q;
	logic [cdqs_pkg::OCC_W-1:0]   out_occ_q;

	logic                  full, empty, is_push, is_pop, mem_we;
	logic [PW-1:0]         head_dec, head_inc, tail_dec, tail_inc, waddr, raddr;
	logic [CW-1:0]         cap_n;
	logic [W-1:0]          vext, pext;
	logic [SW-1:0]         slot_ext, occ_ext;

	assign full     = count_q >= cap_q;
	assign empty    = count_q == '0;
	assign head_dec = ptr_dec(head_q, cap_q);
	assign head_inc = ptr_inc(head_q, cap_q);
	assign tail_dec = ptr_dec(tail_q, cap_q);
	assign tail_inc = ptr_inc(tail_q, cap_q);
	assign is_push  = (cmd_q == cdqs_pkg::CMD_PUSH_FRONT) || (cmd_q == cdqs_pkg::CMD_PUSH_BACK);
	assign is_pop   = (cmd_q == cdqs_pkg::CMD_POP_FRONT) || (cmd_q == cdqs_pkg::CMD_POP_BACK);
	assign mem_we   = ctl.exec && is_push && !full;
	assign waddr    = (cmd_q == cdqs_pkg::CMD_PUSH_FRONT) ? head_dec : tail_q;
	assign raddr    = !ctl.exec ? scan_ptr_q :
	                  ((cmd_q == cdqs_pkg::CMD_POP_BACK) ? tail_dec : head_q);
	assign vext     = W'($unsigned(value));
	assign pext     = W'(rd_data_q);
	assign slot_ext = SW'(rd_slot_q);
	assign occ_ext  = SW'(count_q);

	always_comb begin
		if (capacity == '0) begin
			cap_n = CW'(1);
		end else if (32'(capacity) > DEPTH) begin
			cap_n = CW'(DEPTH);
		end else begin
			cap_n = CW'(capacity);
		end
	end

	assign sts.pop_ok    = is_pop && !empty;
	assign sts.search_go = (cmd_q == cdqs_pkg::CMD_SEARCH) && !empty;
	assign sts.scan_hit  = rd_vld_q && (rd_data_q == val_q);
	assign sts.scan_miss = !rd_vld_q && (issue_left_q == '0);
	assign sts.out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= val_q;
		end
		rd_data_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			cap_q        <= CW'(DEPTH);
			issue_left_q <= '0;
			rd_vld_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q   <= cap_n;
				head_q  <= '0;
				tail_q  <= '0;
				count_q <= '0;
			end else if (ctl.exec) begin
				rd_vld_q <= 1'b0;
				case (cmd_q)
					cdqs_pkg::CMD_PUSH_FRONT: begin
						if (!full) begin
							head_q  <= head_dec;
							count_q <= count_q + CW'(1);
						end
					end
					cdqs_pkg::CMD_PUSH_BACK: begin
						if (!full) begin
							tail_q  <= tail_inc;
							count_q <= count_q + CW'(1);
						end
					end
					cdqs_pkg::CMD_POP_FRONT: begin
						if (!empty) begin
							head_q  <= head_inc;
							count_q <= count_q - CW'(1);
						end
					end
					cdqs_pkg::CMD_POP_BACK: begin
						if (!empty) begin
							tail_q  <= tail_dec;
							count_q <= count_q - CW'(1);
						end
					end
					cdqs_pkg::CMD_SEARCH: begin
						issue_left_q <= count_q;
					end
					default: begin
					end
				endcase
			end else if (ctl.scan_step) begin
				if (issue_left_q != '0) begin
					issue_left_q <= issue_left_q - CW'(1);
					rd_vld_q     <= 1'b1;
				end else begin
					rd_vld_q <= 1'b0;
				end
			end
			if (ctl.finish_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_q <= command;
			val_q <= vext[DATA_WIDTH-1:0];
		end
		if (ctl.exec) begin
			scan_ptr_q   <= head_q;
			res_status_q <= cdqs_pkg::STAT_OK;
			res_popped_q <= '0;
			res_slot_q   <= '0;
			case (cmd_q) inside
				cdqs_pkg::CMD_PUSH_FRONT, cdqs_pkg::CMD_PUSH_BACK: begin
					if (full) begin
						res_status_q <= cdqs_pkg::STAT_FULL;
					end
				end
				cdqs_pkg::CMD_POP_FRONT, cdqs_pkg::CMD_POP_BACK: begin
					if (empty) begin
						res_status_q <= cdqs_pkg::STAT_EMPTY;
						res_popped_q <= '1;
					end
				end
				cdqs_pkg::CMD_SEARCH: begin
					if (empty) begin
						res_status_q <= cdqs_pkg::STAT_NOT_FOUND;
					end
				end
				default: begin
				end
			endcase
		end
		if (ctl.pop_capture) begin
			res_popped_q <= pext[cdqs_pkg::VALUE_W-1:0];
		end
		if (ctl.scan_step) begin
			scan_ptr_q <= ptr_inc(scan_ptr_q, cap_q);
			rd_slot_q  <= scan_ptr_q;
			if (sts.scan_hit) begin
				res_slot_q <= slot_ext[cdqs_pkg::SLOT_W-1:0];
			end else if (sts.scan_miss) begin
				res_status_q <= cdqs_pkg::STAT_NOT_FOUND;
			end
		end
		if (ctl.finish_load) begin
			out_status_q <= res_status_q;
			out_popped_q <= res_popped_q;
			out_slot_q   <= res_slot_q;
			out_occ_q    <= occ_ext[cdqs_pkg::OCC_W-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign popped_value = $signed(out_popped_q);
	assign found_slot   = out_slot_q;
	assign occupancy    = out_occ_q;

endmodule

// ===== sv/circular_deque_with_search.sv =====
`timescale 1ns / 1ps
// circular_deque_with_search: top level, controller plus datapath.
// Depends on cdqs_pkg, cdqs_ctrl and cdqs_dp.
//
// Input channel (in_valid/in_stall) carries one word: command and value.
// Output channel (out_valid/out_stall) returns one result word per input word:
// status, popped_value, found_slot and occupancy after the command.
// Configuration channel (cfg_valid/cfg_ready) writes capacity, clamped to
// 1..DEPTH; every write also empties the deque. Write it only while idle.
// One word is in work at a time. Push, refused pop, search on an empty deque
// and unknown commands go from the execute state straight to the finish
// state; a good pop passes through the pop state (one registered read of the
// slot memory). A search reads one slot per cycle from the front and stops at
// the first match or after the last entry. The next word is taken in the
// cycle after the result is loaded into the output register.
// Reset: deque empty, capacity DEPTH; slot contents are not cleared.
// While the receiver stalls, the result holds in the output register; the
// block still takes and works the next word, then waits to hand it over.

module circular_deque_with_search #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [cdqs_pkg::CMD_W-1:0]          command,
	input  logic signed [cdqs_pkg::VALUE_W-1:0] value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [cdqs_pkg::STAT_W-1:0]         status,
	output logic signed [cdqs_pkg::VALUE_W-1:0] popped_value,
	output logic [cdqs_pkg::SLOT_W-1:0]         found_slot,
	output logic [cdqs_pkg::OCC_W-1:0]          occupancy,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cdqs_pkg::CAP_W-1:0]          capacity
);

	cdqs_pkg::ctl_t ctl;
	cdqs_pkg::sts_t sts;

	cdqs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cfg_ready (cfg_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	cdqs_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.command      (command),
		.value        (value),
		.cfg_we       (cfg_valid && cfg_ready),
		.capacity     (capacity),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.status       (status),
		.popped_value (popped_value),
		.found_slot   (found_slot),
		.occupancy    (occupancy),
		.ctl          (ctl),
		.sts          (sts)
	);

endmodule

// ===== sv/cdqs_checker.sv =====
`timescale 1ns / 1ps
// cdqs_checker: port-level assertions on the result channel, bound to the top.
// Depends on cdqs_pkg for status codes and field widths.

module cdqs_checker #(
	parameter int DEPTH = 64
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [cdqs_pkg::STAT_W-1:0]         status,
	input logic signed [cdqs_pkg::VALUE_W-1:0] popped_value,
	input logic [cdqs_pkg::SLOT_W-1:0]         found_slot,
	input logic [cdqs_pkg::OCC_W-1:0]          occupancy
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(occupancy))
		else $error("result word changed while stalled");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == cdqs_pkg::STAT_EMPTY) |-> (popped_value == -1)
			&& (occupancy == '0) && (found_slot == '0))
		else $error("empty pop word malformed");

	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((status == cdqs_pkg::STAT_FULL) || (status == cdqs_pkg::STAT_NOT_FOUND))
			|-> (popped_value == 0) && (found_slot == '0))
		else $error("refused word carries data");

	a_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(occupancy) <= DEPTH)
			&& !((status == cdqs_pkg::STAT_FULL) && (occupancy == '0)))
		else $error("occupancy out of range");

endmodule

bind circular_deque_with_search cdqs_checker #(.DEPTH(DEPTH)) u_chk (.*);
